// ----- hdl/i2cmse_pkg.sv -----
// Package for the I2C master/slave event controller: field widths, request,
// mode, bus action and bus status codes. No dependencies.
package i2cmse_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int ADDR7_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int QTY_W    = 6;
    localparam int STATUS_W = 5;
    localparam int ACTION_W = 3;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 6;

    localparam logic [BYTE_W-1:0] IDLE_FILL_BYTE = 8'hFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_OPEN_WRITE = 3'd0,
        REQ_PUSH_BYTE  = 3'd1,
        REQ_END_WRITE  = 3'd2,
        REQ_READ       = 3'd3,
        REQ_POP_BYTE   = 3'd4,
        REQ_BUS_EVENT  = 3'd5
    } req_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_READY = 3'd0,
        MODE_MTX   = 3'd1,
        MODE_MRX   = 3'd2,
        MODE_SRX   = 3'd3,
        MODE_STX   = 3'd4
    } mode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_NACK    = 3'd2,
        ACT_START   = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_REP     = 3'd5,
        ACT_RELEASE = 3'd6
    } action_t;

    // Bus status codes, upper five bits of the status byte.
    localparam logic [STATUS_W-1:0] ST_BUS_ERROR        = 5'd0;
    localparam logic [STATUS_W-1:0] ST_START            = 5'd1;
    localparam logic [STATUS_W-1:0] ST_REP_START        = 5'd2;
    localparam logic [STATUS_W-1:0] ST_MT_SLA_ACK       = 5'd3;
    localparam logic [STATUS_W-1:0] ST_MT_SLA_NACK      = 5'd4;
    localparam logic [STATUS_W-1:0] ST_MT_DATA_ACK      = 5'd5;
    localparam logic [STATUS_W-1:0] ST_MT_DATA_NACK     = 5'd6;
    localparam logic [STATUS_W-1:0] ST_ARB_LOST         = 5'd7;
    localparam logic [STATUS_W-1:0] ST_MR_SLA_ACK       = 5'd8;
    localparam logic [STATUS_W-1:0] ST_MR_SLA_NACK      = 5'd9;
    localparam logic [STATUS_W-1:0] ST_MR_DATA_ACK      = 5'd10;
    localparam logic [STATUS_W-1:0] ST_MR_DATA_NACK     = 5'd11;
    localparam logic [STATUS_W-1:0] ST_SR_SLA_ACK       = 5'd12;
    localparam logic [STATUS_W-1:0] ST_SR_ARB_SLA_ACK   = 5'd13;
    localparam logic [STATUS_W-1:0] ST_SR_GCALL_ACK     = 5'd14;
    localparam logic [STATUS_W-1:0] ST_SR_ARB_GCALL_ACK = 5'd15;
    localparam logic [STATUS_W-1:0] ST_SR_DATA_ACK      = 5'd16;
    localparam logic [STATUS_W-1:0] ST_SR_DATA_NACK     = 5'd17;
    localparam logic [STATUS_W-1:0] ST_SR_GDATA_ACK     = 5'd18;
    localparam logic [STATUS_W-1:0] ST_SR_GDATA_NACK    = 5'd19;
    localparam logic [STATUS_W-1:0] ST_SR_STOP          = 5'd20;
    localparam logic [STATUS_W-1:0] ST_ST_SLA_ACK       = 5'd21;
    localparam logic [STATUS_W-1:0] ST_ST_ARB_SLA_ACK   = 5'd22;
    localparam logic [STATUS_W-1:0] ST_ST_DATA_ACK      = 5'd23;
    localparam logic [STATUS_W-1:0] ST_ST_DATA_NACK     = 5'd24;
    localparam logic [STATUS_W-1:0] ST_ST_LAST_DATA     = 5'd25;

endpackage

// ----- hdl/i2c_master_slave_event_controller.sv -----
// I2C master/slave transfer sequencer driven by host requests and bus status events.
// Depends on i2cmse_pkg for widths, request, mode, action and status codes.
//
// Usage: the host and the bus interrupt logic share one input channel
// (in_valid/in_ready). Each word carries a request type with its fields: open
// write, push byte, end write, read request, pop byte, or a bus event (status
// code and received byte). Every accepted word yields exactly one result word on
// the output channel (out_valid/out_ready): the bus action to take, a byte to
// load for the bus, acceptance, popped data, receive count, mode and status.
// Throughput is one word per cycle while each result is taken; out_valid rises in
// the cycle after acceptance, with the registered read port of the buffer memory.
// The scalar state is decided in the cycle of acceptance, and the buffer is read
// at the same edge, so the next word can follow at once without forwarding.
// When the receiver stalls, the result is held in the output register and the
// read data register, and in_ready drops until the result is taken.
// Reset clears the mode to ready, the indices and flags, and sets the stop flag;
// the buffer is not cleared; the user must have it read only where written, and
// write role_slave via cfg_write_en/cfg_write_data only while idle (not enforced).
module i2c_master_slave_event_controller #(
    parameter int BUFFER_DEPTH = i2cmse_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic                               cfg_write_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [i2cmse_pkg::REQ_W-1:0]       req_type,
    input  logic [i2cmse_pkg::ADDR7_W-1:0]     target_address,
    input  logic [i2cmse_pkg::BYTE_W-1:0]      data_byte,
    input  logic [i2cmse_pkg::QTY_W-1:0]       quantity,
    input  logic                               send_stop,
    input  logic [i2cmse_pkg::STATUS_W-1:0]    status_code,
    input  logic [i2cmse_pkg::BYTE_W-1:0]      rx_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [i2cmse_pkg::ACTION_W-1:0]    bus_action,
    output logic [i2cmse_pkg::BYTE_W-1:0]      bus_data,
    output logic                               bus_data_valid,
    output logic                               accepted,
    output logic [i2cmse_pkg::BYTE_W-1:0]      read_data,
    output logic [i2cmse_pkg::COUNT_W-1:0]     byte_count,
    output logic                               rx_done,
    output logic [i2cmse_pkg::MODE_W-1:0]      mode,
    output logic [i2cmse_pkg::STATUS_W-1:0]    last_status,
    output logic [i2cmse_pkg::COUNT_W-1:0]     bytes_available
);
    import i2cmse_pkg::*;

    // Counters must hold the depth itself; the memory index only the entries.
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int QW = (CW > QTY_W) ? CW : QTY_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
    localparam logic [QW-1:0] DEPTH_QW = QW'(BUFFER_DEPTH);

    // Byte buffer, one write and one registered read per cycle.
    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // Scalar state.
    logic              role_reg;
    logic [CW-1:0]     pos_reg,    pos_next;
    logic [CW-1:0]     fill_reg,   fill_next;
    mode_t             mode_reg,   mode_next;
    logic              stop_reg,   stop_next;
    logic              rep_reg,    rep_next;
    logic [BYTE_W-1:0] addr_reg,   addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Result of the word being accepted.
    action_t           act_c;
    logic [BYTE_W-1:0] bdata_c;
    logic              bmem_c;
    logic              bvalid_c;
    logic              acc_c;
    logic              rmem_c;
    logic [COUNT_W-1:0] count_c;
    logic              done_c;
    logic [COUNT_W-1:0] avail_c;

    // Output register.
    logic              out_valid_reg;
    action_t           act_reg;
    logic [BYTE_W-1:0] bdata_reg;
    logic              bmem_reg;
    logic              bvalid_reg;
    logic              acc_reg;
    logic              rmem_reg;
    logic [COUNT_W-1:0] count_reg;
    logic              done_reg;
    mode_t             omode_reg;
    logic [STATUS_W-1:0] ostatus_reg;
    logic [COUNT_W-1:0] avail_reg;

    logic in_fire;
    logic qty_ok;
    logic pos_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign qty_ok   = (quantity != '0) && (QW'(quantity) <= DEPTH_QW);
    assign pos_ok   = (pos_reg < fill_reg) && (pos_reg < DEPTH_C);

    always_comb
    begin
        logic [CW:0] want;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        mode_next   = mode_reg;
        stop_next   = stop_reg;
        rep_next    = rep_reg;
        addr_next   = addr_reg;
        status_next = status_reg;
        act_c       = ACT_NONE;
        bdata_c     = '0;
        bmem_c      = 1'b0;
        bvalid_c    = 1'b0;
        acc_c       = 1'b0;
        rmem_c      = 1'b0;
        count_c     = '0;
        done_c      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg[AW-1:0];
        mem_wdata   = rx_data;
        mem_re      = 1'b0;
        mem_raddr   = pos_reg[AW-1:0];
        want        = '0;

        case (req_t'(req_type))
            REQ_OPEN_WRITE:
            begin
                if (!role_reg && mode_reg == MODE_READY)
                begin
                    mode_next = MODE_MTX;
                    addr_next = {target_address, 1'b0};
                    pos_next  = '0;
                    fill_next = '0;
                    acc_c     = 1'b1;
                end
            end
            REQ_PUSH_BYTE:
            begin
                if (fill_reg < DEPTH_C)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fill_reg[AW-1:0];
                    mem_wdata = data_byte;
                    fill_next = fill_reg + CW'(1);
                    acc_c     = 1'b1;
                end
            end
            REQ_END_WRITE, REQ_READ:
            begin
                if (!role_reg &&
                    ((req_t'(req_type) == REQ_END_WRITE && mode_reg == MODE_MTX) ||
                     (req_t'(req_type) == REQ_READ && mode_reg == MODE_READY && qty_ok)))
                begin
                    stop_next = send_stop;
                    acc_c     = 1'b1;
                    if (req_t'(req_type) == REQ_READ)
                    begin
                        mode_next = MODE_MRX;
                        pos_next  = '0;
                        fill_next = CW'(QW'(quantity) - QW'(1));
                        addr_next = {target_address, 1'b1};
                    end
                    // A pending repeated start goes straight to the address byte.
                    if (rep_reg)
                    begin
                        rep_next = 1'b0;
                        bdata_c  = addr_next;
                        bvalid_c = 1'b1;
                        act_c    = ACT_ACK;
                    end
                    else
                    begin
                        act_c = ACT_START;
                    end
                end
            end
            REQ_POP_BYTE:
            begin
                if (pos_ok)
                begin
                    mem_re   = 1'b1;
                    rmem_c   = 1'b1;
                    pos_next = pos_reg + CW'(1);
                    acc_c    = 1'b1;
                end
            end
            REQ_BUS_EVENT:
            begin
                status_next = status_code;
                case (status_code) inside
                    ST_START, ST_REP_START:
                    begin
                        bdata_c  = addr_reg;
                        bvalid_c = 1'b1;
                        act_c    = ACT_ACK;
                    end
                    ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                    begin
                        if (pos_ok)
                        begin
                            mem_re   = 1'b1;
                            bmem_c   = 1'b1;
                            bvalid_c = 1'b1;
                            pos_next = pos_reg + CW'(1);
                            act_c    = ACT_ACK;
                        end
                        else
                        begin
                            mode_next = MODE_READY;
                            if (stop_reg)
                            begin
                                act_c = ACT_STOP;
                            end
                            else
                            begin
                                rep_next = 1'b1;
                                act_c    = ACT_REP;
                            end
                        end
                    end
                    ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK, ST_BUS_ERROR:
                    begin
                        act_c     = ACT_STOP;
                        mode_next = MODE_READY;
                    end
                    ST_ARB_LOST:
                    begin
                        act_c     = ACT_RELEASE;
                        mode_next = MODE_READY;
                    end
                    ST_MR_SLA_ACK, ST_MR_DATA_ACK:
                    begin
                        if (status_code == ST_MR_DATA_ACK && pos_reg < DEPTH_C)
                        begin
                            mem_we   = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                        act_c = (pos_next < fill_reg) ? ACT_ACK : ACT_NACK;
                    end
                    ST_MR_DATA_NACK:
                    begin
                        if (pos_reg < DEPTH_C)
                        begin
                            mem_we   = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                        mode_next = MODE_READY;
                        if (stop_reg)
                        begin
                            act_c = ACT_STOP;
                        end
                        else
                        begin
                            rep_next = 1'b1;
                            act_c    = ACT_REP;
                        end
                    end
                    [ST_SR_SLA_ACK:ST_SR_ARB_GCALL_ACK]:
                    begin
                        mode_next = MODE_SRX;
                        pos_next  = '0;
                        act_c     = ACT_ACK;
                    end
                    ST_SR_DATA_ACK, ST_SR_GDATA_ACK:
                    begin
                        if (pos_reg < DEPTH_C)
                        begin
                            mem_we   = 1'b1;
                            pos_next = pos_reg + CW'(1);
                            act_c    = ACT_ACK;
                        end
                        else
                        begin
                            act_c = ACT_NACK;
                        end
                    end
                    ST_SR_DATA_NACK, ST_SR_GDATA_NACK:
                    begin
                        act_c = ACT_NACK;
                    end
                    ST_SR_STOP:
                    begin
                        fill_next = pos_reg;
                        pos_next  = '0;
                        count_c   = COUNT_W'(pos_reg);
                        done_c    = 1'b1;
                        act_c     = ACT_RELEASE;
                        mode_next = MODE_READY;
                    end
                    ST_ST_SLA_ACK, ST_ST_ARB_SLA_ACK:
                    begin
                        // The buffer becomes a single idle byte, sent at once.
                        mode_next = MODE_STX;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = IDLE_FILL_BYTE;
                        fill_next = CW'(1);
                        pos_next  = CW'(1);
                        bvalid_c  = 1'b1;
                        bdata_c   = IDLE_FILL_BYTE;
                        act_c     = ACT_NACK;
                    end
                    ST_ST_DATA_ACK:
                    begin
                        bvalid_c = 1'b1;
                        if (pos_ok)
                        begin
                            mem_re   = 1'b1;
                            bmem_c   = 1'b1;
                            pos_next = pos_reg + CW'(1);
                        end
                        else
                        begin
                            bdata_c = IDLE_FILL_BYTE;
                        end
                        act_c = (pos_next < fill_reg) ? ACT_ACK : ACT_NACK;
                    end
                    ST_ST_DATA_NACK, ST_ST_LAST_DATA:
                    begin
                        act_c     = ACT_ACK;
                        mode_next = MODE_READY;
                    end
                    default:
                    begin
                    end
                endcase

                // Leaving master receive settles the count of bytes received.
                if (mode_reg == MODE_MRX && mode_next != MODE_MRX && !done_c)
                begin
                    want      = {1'b0, fill_next} + (CW + 1)'(1);
                    fill_next = ({1'b0, pos_next} < want) ? pos_next : want[CW-1:0];
                    pos_next  = '0;
                    count_c   = COUNT_W'(fill_next);
                end
            end
            default:
            begin
            end
        endcase

        avail_c = (fill_next > pos_next) ? COUNT_W'(fill_next - pos_next) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire && mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg   <= 1'b0;
            pos_reg    <= '0;
            fill_reg   <= '0;
            mode_reg   <= MODE_READY;
            stop_reg   <= 1'b1;
            rep_reg    <= 1'b0;
            addr_reg   <= '0;
            status_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                role_reg <= cfg_write_data;
            end
            if (in_fire)
            begin
                pos_reg    <= pos_next;
                fill_reg   <= fill_next;
                mode_reg   <= mode_next;
                stop_reg   <= stop_next;
                rep_reg    <= rep_next;
                addr_reg   <= addr_next;
                status_reg <= status_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg     <= act_c;
            bdata_reg   <= bdata_c;
            bmem_reg    <= bmem_c;
            bvalid_reg  <= bvalid_c;
            acc_reg     <= acc_c;
            rmem_reg    <= rmem_c;
            count_reg   <= count_c;
            done_reg    <= done_c;
            omode_reg   <= mode_next;
            ostatus_reg <= status_next;
            avail_reg   <= avail_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign bus_action      = act_reg;
    assign bus_data        = bmem_reg ? mem_q_reg : bdata_reg;
    assign bus_data_valid  = bvalid_reg;
    assign accepted        = acc_reg;
    assign read_data       = rmem_reg ? mem_q_reg : '0;
    assign byte_count      = count_reg;
    assign rx_done         = done_reg;
    assign mode            = omode_reg;
    assign last_status     = ostatus_reg;
    assign bytes_available = avail_reg;

    // The indices never run past the buffer.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= DEPTH_C) && (fill_reg <= DEPTH_C))
        else $error("buffer index beyond depth");

    // Every accepted word produces a result in the following cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word without a result");

    // A finished slave receive leaves the block ready.
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (omode_reg == MODE_READY))
        else $error("receive done while not ready");

    // A buffer byte is only presented together with a load request.
    a_mem_byte_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bmem_reg) |-> (bvalid_reg && !rmem_reg))
        else $error("buffer byte routed without load request");

    // A popped byte always reports acceptance.
    a_pop_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rmem_reg) |-> acc_reg)
        else $error("popped byte not marked accepted");

endmodule

// ----- test/i2c_master_slave_event_controller_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_slave_event_controller: host requests and
// bus status events in, one response word out per request. Depends on i2cmse_pkg
// and the controller RTL only.
module i2c_master_slave_event_controller_tb;
    import i2cmse_pkg::*;

    // Run length and pressure settings.
    localparam int  RANDOM_WORDS    = 1025;
    localparam int  PHASES          = 5;
    localparam int  HOLD_OFF_CYCLES = 200;
    localparam int  RUN_LIMIT_NS    = 5_000_000;
    localparam int  DRAIN_LIMIT     = 2000;
    // Status codes above the last defined one; the block only records them.
    localparam logic [STATUS_W-1:0] ST_FIRST_UNUSED = 5'd26;
    localparam logic [STATUS_W-1:0] ST_LAST_UNUSED  = 5'd31;

    // One word on the request channel, every field as on the ports.
    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [ADDR7_W-1:0]  addr;
        logic [BYTE_W-1:0]   data;
        logic [QTY_W-1:0]    qty;
        logic                stop;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   rx;
    } word_t;

    // One word on the response channel.
    typedef struct packed {
        action_t             action;
        logic [BYTE_W-1:0]   data;
        logic                data_valid;
        logic                accepted;
        logic [BYTE_W-1:0]   read_data;
        logic [COUNT_W-1:0]  count;
        logic                rx_done;
        mode_t               mode;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  avail;
    } response_t;

    // The scoreboard carries its own copy of the sequencer state. Each accepted
    // request word is run through the prediction at once and the response it
    // should produce is queued; response words are checked against the queue in
    // order. It also remembers which buffer entries have ever been written, so
    // that the stimulus never makes the block read an entry that holds nothing.
    class twi_response_board;
        int unsigned         errors;
        response_t           awaited_responses[$];
        bit                  role_slave;
        logic [BYTE_W-1:0]   byte_store [BUFFER_DEPTH_DEF];
        bit                  written [BUFFER_DEPTH_DEF];
        int unsigned         position;
        int unsigned         fill_count;
        mode_t               cur_mode = MODE_READY;
        bit                  stop_flag = 1'b1;
        bit                  repeat_start = 1'b0;
        logic [BYTE_W-1:0]   address_byte = '0;
        logic [STATUS_W-1:0] status_reg = '0;

        function void set_role(bit slave);
            role_slave = slave;
        endfunction

        function int unsigned outstanding();
            return awaited_responses.size();
        endfunction

        // True when the word would read a buffer entry that was never written.
        function bit reads_unwritten(word_t w);
            bit reads;
            reads = 1'b0;
            if (w.req == REQ_POP_BYTE)
                reads = 1'b1;
            else if (w.req == REQ_BUS_EVENT)
                case (w.status)
                    ST_MT_SLA_ACK, ST_MT_DATA_ACK, ST_ST_DATA_ACK: reads = 1'b1;
                    default: ;
                endcase
            return reads && position < fill_count && position < BUFFER_DEPTH_DEF
                   && !written[position];
        endfunction

        function void store_rx(logic [BYTE_W-1:0] b);
            if (position < BUFFER_DEPTH_DEF) begin
                byte_store[position] = b;
                written[position] = 1'b1;
                position++;
            end
        endfunction

        function action_t finish_transfer();
            cur_mode = MODE_READY;
            if (stop_flag)
                return ACT_STOP;
            repeat_start = 1'b1;
            return ACT_REP;
        endfunction

        // After a repeated start the address goes straight out; otherwise a start.
        function void launch_address(inout response_t r);
            if (repeat_start) begin
                repeat_start = 1'b0;
                r.data = address_byte;
                r.data_valid = 1'b1;
                r.action = ACT_ACK;
            end else begin
                r.action = ACT_START;
            end
        endfunction

        function response_t predict_response(word_t w);
            response_t   r;
            mode_t       prior;
            bit          slave_done;
            int unsigned want;
            r = '0;
            prior = cur_mode;
            slave_done = 1'b0;
            case (w.req)
                REQ_OPEN_WRITE:
                    if (!role_slave && cur_mode == MODE_READY) begin
                        cur_mode = MODE_MTX;
                        address_byte = {w.addr, 1'b0};
                        position = 0;
                        fill_count = 0;
                        r.accepted = 1'b1;
                    end
                REQ_PUSH_BYTE:
                    if (fill_count < BUFFER_DEPTH_DEF) begin
                        byte_store[fill_count] = w.data;
                        written[fill_count] = 1'b1;
                        fill_count++;
                        r.accepted = 1'b1;
                    end
                REQ_END_WRITE:
                    if (!role_slave && cur_mode == MODE_MTX) begin
                        stop_flag = w.stop;
                        launch_address(r);
                        r.accepted = 1'b1;
                    end
                REQ_READ:
                    if (!role_slave && cur_mode == MODE_READY && w.qty != 0
                        && w.qty <= BUFFER_DEPTH_DEF) begin
                        cur_mode = MODE_MRX;
                        stop_flag = w.stop;
                        position = 0;
                        fill_count = w.qty - 1;
                        address_byte = {w.addr, 1'b1};
                        launch_address(r);
                        r.accepted = 1'b1;
                    end
                REQ_POP_BYTE:
                    if (position < fill_count && position < BUFFER_DEPTH_DEF) begin
                        r.read_data = byte_store[position];
                        position++;
                        r.accepted = 1'b1;
                    end
                REQ_BUS_EVENT: begin
                    status_reg = w.status;
                    case (w.status)
                        ST_START, ST_REP_START: begin
                            r.data = address_byte;
                            r.data_valid = 1'b1;
                            r.action = ACT_ACK;
                        end
                        ST_MT_SLA_ACK, ST_MT_DATA_ACK:
                            if (position < fill_count && position < BUFFER_DEPTH_DEF) begin
                                r.data = byte_store[position];
                                position++;
                                r.data_valid = 1'b1;
                                r.action = ACT_ACK;
                            end else begin
                                r.action = finish_transfer();
                            end
                        ST_BUS_ERROR, ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
                            r.action = ACT_STOP;
                            cur_mode = MODE_READY;
                        end
                        ST_ARB_LOST: begin
                            r.action = ACT_RELEASE;
                            cur_mode = MODE_READY;
                        end
                        ST_MR_SLA_ACK, ST_MR_DATA_ACK: begin
                            if (w.status == ST_MR_DATA_ACK)
                                store_rx(w.rx);
                            r.action = (position < fill_count) ? ACT_ACK : ACT_NACK;
                        end
                        ST_MR_DATA_NACK: begin
                            store_rx(w.rx);
                            r.action = finish_transfer();
                        end
                        ST_SR_SLA_ACK, ST_SR_ARB_SLA_ACK, ST_SR_GCALL_ACK,
                        ST_SR_ARB_GCALL_ACK: begin
                            cur_mode = MODE_SRX;
                            position = 0;
                            r.action = ACT_ACK;
                        end
                        ST_SR_DATA_ACK, ST_SR_GDATA_ACK:
                            if (position < BUFFER_DEPTH_DEF) begin
                                store_rx(w.rx);
                                r.action = ACT_ACK;
                            end else begin
                                r.action = ACT_NACK;
                            end
                        ST_SR_DATA_NACK, ST_SR_GDATA_NACK:
                            r.action = ACT_NACK;
                        ST_SR_STOP: begin
                            fill_count = position;
                            position = 0;
                            r.count = COUNT_W'(fill_count);
                            r.rx_done = 1'b1;
                            slave_done = 1'b1;
                            r.action = ACT_RELEASE;
                            cur_mode = MODE_READY;
                        end
                        ST_ST_SLA_ACK, ST_ST_ARB_SLA_ACK, ST_ST_DATA_ACK: begin
                            if (w.status != ST_ST_DATA_ACK) begin
                                cur_mode = MODE_STX;
                                position = 0;
                                byte_store[0] = IDLE_FILL_BYTE;
                                written[0] = 1'b1;
                                fill_count = 1;
                            end
                            r.data_valid = 1'b1;
                            if (position < fill_count && position < BUFFER_DEPTH_DEF) begin
                                r.data = byte_store[position];
                                position++;
                            end else begin
                                r.data = IDLE_FILL_BYTE;
                            end
                            r.action = (position < fill_count) ? ACT_ACK : ACT_NACK;
                        end
                        ST_ST_DATA_NACK, ST_ST_LAST_DATA: begin
                            r.action = ACT_ACK;
                            cur_mode = MODE_READY;
                        end
                        default: ;
                    endcase
                    // Leaving master receive by any route settles the received count.
                    if (prior == MODE_MRX && cur_mode != MODE_MRX && !slave_done) begin
                        want = fill_count + 1;
                        fill_count = (position < want) ? position : want;
                        position = 0;
                        r.count = COUNT_W'(fill_count);
                    end
                end
                default: ;
            endcase
            r.mode = cur_mode;
            r.status = status_reg;
            r.avail = (fill_count > position) ? COUNT_W'(fill_count - position) : '0;
            return r;
        endfunction

        function void note_word(word_t w);
            awaited_responses.push_back(predict_response(w));
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(response_t got);
            response_t want;
            if (awaited_responses.size() == 0) begin
                $display("%0t: response word arrived with none expected", $time);
                errors++;
                return;
            end
            want = awaited_responses.pop_front();
            compare_field("bus_action", want.action, got.action);
            compare_field("bus_data", want.data, got.data);
            compare_field("bus_data_valid", want.data_valid, got.data_valid);
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("byte_count", want.count, got.count);
            compare_field("rx_done", want.rx_done, got.rx_done);
            compare_field("mode", want.mode, got.mode);
            compare_field("last_status", want.status, got.status);
            compare_field("bytes_available", want.avail, got.avail);
        endfunction
    endclass

    // Clock, reset and every input start from known values.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic                  cfg_write_data = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type = '0;
    logic [ADDR7_W-1:0]    target_address = '0;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic [QTY_W-1:0]      quantity = '0;
    logic                  send_stop = 1'b0;
    logic [STATUS_W-1:0]   status_code = '0;
    logic [BYTE_W-1:0]     rx_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [ACTION_W-1:0]   bus_action;
    logic [BYTE_W-1:0]     bus_data;
    logic                  bus_data_valid;
    logic                  accepted;
    logic [BYTE_W-1:0]     read_data;
    logic [COUNT_W-1:0]    byte_count;
    logic                  rx_done;
    logic [MODE_W-1:0]     mode;
    logic [STATUS_W-1:0]   last_status;
    logic [COUNT_W-1:0]    bytes_available;

    twi_response_board sb;
    int unsigned       issued;
    bit                calm;             // no idling on either side
    bit                hold_off_request; // asks the response side for a long stall

    always #6 clk = ~clk;

    i2c_master_slave_event_controller uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .target_address  (target_address),
        .data_byte       (data_byte),
        .quantity        (quantity),
        .send_stop       (send_stop),
        .status_code     (status_code),
        .rx_data         (rx_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bus_action      (bus_action),
        .bus_data        (bus_data),
        .bus_data_valid  (bus_data_valid),
        .accepted        (accepted),
        .read_data       (read_data),
        .byte_count      (byte_count),
        .rx_done         (rx_done),
        .mode            (mode),
        .last_status     (last_status),
        .bytes_available (bytes_available)
    );

    // Response side: every word taken is checked. Values are sampled at the edge,
    // before any of this edge's updates take effect.
    always @(posedge clk) begin : response_monitor
        response_t got;
        if (rst_n && out_valid && out_ready) begin
            got.action     = action_t'(bus_action);
            got.data       = bus_data;
            got.data_valid = bus_data_valid;
            got.accepted   = accepted;
            got.read_data  = read_data;
            got.count      = byte_count;
            got.rx_done    = rx_done;
            got.mode       = mode_t'(mode);
            got.status     = last_status;
            got.avail      = bytes_available;
            sb.check_word(got);
        end
    end

    // Response side back-pressure: short random stalls, plus one long stretch on
    // request, long enough for the block to fill and drop in_ready.
    initial begin : response_stall
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // A word with every field random; the sequences then fix what matters.
    function automatic word_t fresh(logic [REQ_W-1:0] req);
        word_t w;
        w.req    = req;
        w.addr   = ADDR7_W'($urandom_range(0, 127));
        w.data   = BYTE_W'($urandom_range(0, 255));
        w.qty    = QTY_W'($urandom_range(0, 63));
        w.stop   = 1'($urandom_range(0, 1));
        w.status = STATUS_W'($urandom_range(0, 31));
        w.rx     = BYTE_W'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic word_t bus_event(logic [STATUS_W-1:0] code);
        word_t w;
        w = fresh(REQ_BUS_EVENT);
        w.status = code;
        return w;
    endfunction

    // Called at a rising edge. Holds the word until it is taken, then records it.
    task automatic send_word(word_t w);
        in_valid       <= 1'b1;
        req_type       <= w.req;
        target_address <= w.addr;
        data_byte      <= w.data;
        quantity       <= w.qty;
        send_stop      <= w.stop;
        status_code    <= w.status;
        rx_data        <= w.rx;
        do @(posedge clk); while (!in_ready);
        sb.note_word(w);
        if (w.req <= REQ_BUS_EVENT)
            issued++;
    endtask

    task automatic pause(int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // A word that would read a never-written buffer entry is swapped for an
    // unused status code, which only updates last_status.
    task automatic issue(word_t w);
        if (sb.reads_unwritten(w)) begin
            w.req = REQ_BUS_EVENT;
            w.status = STATUS_W'($urandom_range(ST_FIRST_UNUSED, ST_LAST_UNUSED));
        end
        if (!calm && $urandom_range(0, 9) == 0)
            pause($urandom_range(1, 16));
        send_word(w);
    endtask

    // Stop offering words until every expected response has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // The role register is only written with the block idle.
    task automatic write_role(bit slave);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= slave;
        @(posedge clk);
        sb.set_role(slave);
        cfg_write_en   <= 1'b0;
    endtask

    // Open, push n bytes, end, then the bus events of a master write, which can stop early.
    task automatic master_write();
        word_t w;
        int    n;
        int    k;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 34) : $urandom_range(0, 6);
        issue(fresh(REQ_OPEN_WRITE));
        for (k = 0; k < n; k++)
            issue(fresh(REQ_PUSH_BYTE));
        issue(fresh(REQ_END_WRITE));
        issue(bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START));
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0:       w = bus_event(ST_MT_SLA_NACK);
                1:       w = bus_event(ST_ARB_LOST);
                default: w = bus_event(ST_BUS_ERROR);
            endcase
            issue(w);
            return;
        end
        issue(bus_event(ST_MT_SLA_ACK));
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                issue(bus_event(ST_MT_DATA_NACK));
                return;
            end
            issue(bus_event(ST_MT_DATA_ACK));
        end
    endtask

    // Read request (rejected quantities stop here), address phase (which may be NACKed), q-1 acknowledged bytes,
    // the last one not acknowledged, then pop none, some, all or more than all of the result.
    task automatic master_read();
        word_t w;
        int    q;
        int    k;
        case ($urandom_range(0, 11))
            0:       q = 0;
            1:       q = $urandom_range(BUFFER_DEPTH_DEF + 1, 63);
            2, 3:    q = BUFFER_DEPTH_DEF;
            default: q = $urandom_range(1, 6);
        endcase
        w = fresh(REQ_READ);
        w.qty = QTY_W'(q);
        issue(w);
        if (q == 0 || q > BUFFER_DEPTH_DEF)
            return;
        issue(bus_event($urandom_range(0, 1) ? ST_START : ST_REP_START));
        if ($urandom_range(0, 7) == 0) begin
            issue(bus_event(ST_MR_SLA_NACK));
            return;
        end
        issue(bus_event(ST_MR_SLA_ACK));
        for (k = 1; k < q; k++)
            issue(bus_event(ST_MR_DATA_ACK));
        issue(bus_event(ST_MR_DATA_NACK));
        repeat ($urandom_range(0, q + 1))
            issue(fresh(REQ_POP_BYTE));
    endtask

    // Addressed as a slave, receive bytes up to and past the buffer depth,
    // stop condition, then pop.
    task automatic slave_receive();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 6);
        issue(bus_event(STATUS_W'($urandom_range(ST_SR_SLA_ACK, ST_SR_ARB_GCALL_ACK))));
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       issue(bus_event($urandom_range(0, 1) ? ST_SR_DATA_NACK
                                                              : ST_SR_GDATA_NACK));
                default: issue(bus_event($urandom_range(0, 1) ? ST_SR_DATA_ACK
                                                              : ST_SR_GDATA_ACK));
            endcase
        end
        issue(bus_event(ST_SR_STOP));
        repeat ($urandom_range(0, n + 1))
            issue(fresh(REQ_POP_BYTE));
    endtask

    task automatic slave_transmit();
        issue(bus_event($urandom_range(0, 1) ? ST_ST_SLA_ACK : ST_ST_ARB_SLA_ACK));
        repeat ($urandom_range(0, 3))
            issue(bus_event(ST_ST_DATA_ACK));
        issue(bus_event($urandom_range(0, 1) ? ST_ST_DATA_NACK : ST_ST_LAST_DATA));
    endtask

    // Anything at all, including the two unused request types.
    task automatic noise();
        issue(fresh(REQ_W'($urandom_range(0, 7))));
    endtask

    task automatic run_sequence(bit slave);
        int roll;
        roll = $urandom_range(0, 99);
        if (!slave) begin
            if (roll < 35)      master_write();
            else if (roll < 70) master_read();
            else if (roll < 80) slave_receive();
            else if (roll < 85) slave_transmit();
            else                noise();
        end else begin
            if (roll < 40)      slave_receive();
            else if (roll < 65) slave_transmit();
            else if (roll < 75) master_write();
            else if (roll < 80) master_read();
            else                noise();
        end
    endtask

    // Directed opening: rejections, a short write and read, slave transmit past
    // the end of its buffer, and an unused status code.
    task automatic directed();
        word_t w;
        issue(fresh(REQ_POP_BYTE));                       // pop with nothing stored
        issue(fresh(REQ_END_WRITE));                      // end with no write open
        w = fresh(REQ_READ);  w.qty = 0;  issue(w);       // zero quantity
        w = fresh(REQ_READ);  w.qty = QTY_W'(BUFFER_DEPTH_DEF + 1);  issue(w);
        w = fresh(REQ_OPEN_WRITE);  w.addr = 7'h7F;  issue(w);
        w = fresh(REQ_OPEN_WRITE);  w.addr = 7'h00;  issue(w);   // busy start
        w = fresh(REQ_READ);  w.qty = 4;  issue(w);              // busy start
        w = fresh(REQ_PUSH_BYTE);  w.data = 8'hFF;  issue(w);
        w = fresh(REQ_PUSH_BYTE);  w.data = 8'h00;  issue(w);
        w = fresh(REQ_END_WRITE);  w.stop = 1'b1;  issue(w);
        issue(bus_event(ST_START));
        issue(bus_event(ST_MT_SLA_ACK));
        issue(bus_event(ST_MT_DATA_ACK));
        issue(bus_event(ST_MT_DATA_ACK));                 // finishes with a stop
        w = fresh(REQ_READ);  w.addr = 7'h00;  w.qty = 2;  w.stop = 1'b0;  issue(w);
        issue(bus_event(ST_START));
        issue(bus_event(ST_MR_SLA_ACK));
        w = bus_event(ST_MR_DATA_ACK);  w.rx = 8'hFF;  issue(w);
        w = bus_event(ST_MR_DATA_NACK);  w.rx = 8'h00;  issue(w);  // repeated start
        issue(fresh(REQ_POP_BYTE));
        issue(fresh(REQ_POP_BYTE));
        w = fresh(REQ_READ);  w.qty = QTY_W'(BUFFER_DEPTH_DEF);  issue(w);  // address at once
        issue(bus_event(ST_ARB_LOST));                    // read ends with nothing read
        issue(bus_event(ST_ST_SLA_ACK));
        issue(bus_event(ST_ST_DATA_ACK));                 // past the end of the data
        issue(bus_event(ST_ST_LAST_DATA));
        issue(bus_event(ST_LAST_UNUSED));
    endtask

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_end;
        int          ph;
        int          k;
        sb = new;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_role(1'b0);
        directed();
        // Phases alternate the role, starting and ending in master role. The
        // last phase runs with no idling on either side.
        for (ph = 0; ph < PHASES; ph++) begin
            write_role(1'(ph % 2));
            calm = (ph == PHASES - 1);
            phase_end = issued + RANDOM_WORDS / PHASES;
            if (ph == 0)
                hold_off_request = 1'b1;
            while (issued < phase_end) begin
                run_sequence(1'(ph % 2));
                if (ph == 2 && issued >= phase_end - RANDOM_WORDS / (2 * PHASES)
                    && issued < phase_end - RANDOM_WORDS / (2 * PHASES) + 8)
                    drain();
            end
        end
        in_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && sb.outstanding() != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.outstanding() != 0)
            $display("%0t: %0d response words never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
